[rtl/drifting_ellipse_kernel_sum_core_macros.svh]
// Assertion macros for the drifting ellipse kernel sum core.
`ifndef DRIFTING_ELLIPSE_KERNEL_SUM_CORE_MACROS_SVH
`define DRIFTING_ELLIPSE_KERNEL_SUM_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DREK_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("drek assertion failed");
`define DREK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("drek sequencing assertion failed");
`else
`define DREK_ASSERT(label, prop)
`define DREK_NEXT(label, ante, cons)
`endif
`endif

[rtl/drek_pkg.sv]
// Shared types and codes of the drifting ellipse kernel sum core.
`default_nettype none
package drek_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    CFG_COS     = 3'd0,
    CFG_SIN     = 3'd1,
    CFG_INV_A   = 3'd2,
    CFG_INV_B   = 3'd3,
    CFG_DRIFT_X = 3'd4,
    CFG_DRIFT_Y = 3'd5,
    CFG_WINDOW  = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] t;
    logic signed [31:0] w;
  } point_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] t;
  } site_t;

  typedef struct packed {
    logic signed [15:0] cos_a;
    logic signed [15:0] sin_a;
    logic [31:0]        inv_a;
    logic [31:0]        inv_b;
    logic signed [31:0] drift_x;
    logic signed [31:0] drift_y;
    logic [30:0]        window;
  } cfg_t;

  // Per-point tag that travels beside the evaluation pipeline.
  typedef struct packed {
    logic               vld;
    logic               last;
    logic               keep;
    logic signed [31:0] w;
  } tag_t;

  localparam int unsigned EVAL_STAGES = 10;

endpackage
`default_nettype wire

[rtl/drifting_ellipse_kernel_sum_core.sv]
// Drifting ellipse kernel sum core: kernel point chain, evaluator and sequencer.
// Flow: a query rotates the point chain once through the 10 evaluator stages,
//   then the clamped sum is registered onto the result channel.
// Throughput: while idle, clear and load take one beat per cycle; the command
//   channel stalls while a query is in progress.
// Reset: synchronous active-low rst_n empties the table, restores the register
//   defaults and drops any pending result; point storage is not cleared.
`default_nettype none
`include "drifting_ellipse_kernel_sum_core_macros.svh"
module drifting_ellipse_kernel_sum_core #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration write channel
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  // command channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_cmd,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_t,
  input  wire logic signed [31:0] in_weight,
  input  wire logic signed [47:0] in_base_sum,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [47:0]      out_total,
  output logic                    out_saturated
);

  localparam int unsigned CNTW = $clog2(MAX_POINTS + 1);
  localparam int unsigned IDXW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam logic [IDXW-1:0] IDX_LAST = IDXW'(MAX_POINTS - 1);
  localparam logic [CNTW-1:0] CNT_FULL = CNTW'(MAX_POINTS);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  drek_pkg::cfg_t   cfg_r;
  drek_pkg::site_t  site_r;
  drek_pkg::point_t new_pt, chain_in;
  drek_pkg::point_t cell_q [MAX_POINTS];
  drek_pkg::tag_t   hit;

  logic [CNTW-1:0]    count_r, count_nxt;
  logic [IDXW-1:0]    k_r, k_nxt;
  logic signed [57:0] acc_r, acc_nxt;
  logic               out_valid_r;
  logic signed [47:0] out_total_r;
  logic               out_sat_r;

  logic in_beat, load_ok, rotate, shift, out_free, acc_ovf;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_beat   = in_valid && !in_stall;
  assign load_ok   = in_beat && (in_cmd == drek_pkg::CMD_LOAD) && (count_r < CNT_FULL);
  assign rotate    = (state_r == ST_RUN);
  assign shift     = rotate || load_ok;
  assign out_free  = !out_valid_r || !out_stall;

  // Configuration registers; unknown indexes fall through.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cos_a   <= 16'sd16384;
      cfg_r.sin_a   <= '0;
      cfg_r.inv_a   <= 32'd65536;
      cfg_r.inv_b   <= 32'd65536;
      cfg_r.drift_x <= '0;
      cfg_r.drift_y <= '0;
      cfg_r.window  <= 31'd65536;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        drek_pkg::CFG_COS:     cfg_r.cos_a   <= cfg_data[15:0];
        drek_pkg::CFG_SIN:     cfg_r.sin_a   <= cfg_data[15:0];
        drek_pkg::CFG_INV_A:   cfg_r.inv_a   <= cfg_data;
        drek_pkg::CFG_INV_B:   cfg_r.inv_b   <= cfg_data;
        drek_pkg::CFG_DRIFT_X: cfg_r.drift_x <= cfg_data;
        drek_pkg::CFG_DRIFT_Y: cfg_r.drift_y <= cfg_data;
        drek_pkg::CFG_WINDOW:  cfg_r.window  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Point chain: a load pushes the new point into cell 0, a query rotates the
  // whole ring once so every cell passes the head exactly one time.
  assign new_pt.x = in_pos_x;
  assign new_pt.y = in_pos_y;
  assign new_pt.t = in_pos_t;
  assign new_pt.w = in_weight;
  assign chain_in = rotate ? cell_q[MAX_POINTS-1] : new_pt;

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    if (i == 0) begin : g_head
      drek_cell u_cell (.clk(clk), .shift(shift), .d(chain_in), .q(cell_q[i]));
    end else begin : g_body
      drek_cell u_cell (.clk(clk), .shift(shift), .d(cell_q[i-1]), .q(cell_q[i]));
    end
  end

  // Head of the ring holds original cell k_r; cells below count are live.
  drek_eval u_eval (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .site    (site_r),
    .pt_vld  (rotate && (CNTW'(k_r) < count_r)),
    .pt_last (rotate && (k_r == '0)),
    .pt      (cell_q[MAX_POINTS-1]),
    .hit     (hit)
  );

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    k_nxt     = k_r;
    acc_nxt   = acc_r;
    if (hit.keep) begin
      acc_nxt = acc_r + 58'(hit.w);
    end
    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          case (in_cmd)
            drek_pkg::CMD_CLEAR: count_nxt = '0;
            drek_pkg::CMD_LOAD: begin
              if (load_ok) begin
                count_nxt = count_r + CNTW'(1);
              end
            end
            drek_pkg::CMD_QUERY: begin
              acc_nxt   = 58'(in_base_sum);
              k_nxt     = IDX_LAST;
              state_nxt = ST_RUN;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        if (k_r == '0) begin
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r - IDXW'(1);
        end
      end
      ST_DRAIN: begin
        if (hit.last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      k_r     <= k_nxt;
    end
    acc_r <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_beat && (in_cmd == drek_pkg::CMD_QUERY)) begin
      site_r.x <= in_pos_x;
      site_r.y <= in_pos_y;
      site_r.t <= in_pos_t;
    end
  end

  // Clamp the exact sum to 48 bits when the top bits disagree.
  assign acc_ovf = !((acc_r[57:47] == '0) || (acc_r[57:47] == '1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_sat_r <= acc_ovf;
      if (acc_ovf) begin
        out_total_r <= acc_r[57] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end else begin
        out_total_r <= acc_r[47:0];
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_total     = out_total_r;
  assign out_saturated = out_sat_r;

  `DREK_ASSERT(a_count_max, count_r <= CNT_FULL)
  `DREK_ASSERT(a_last_in_drain, hit.last |-> (state_r == ST_DRAIN))
  `DREK_NEXT(a_run_to_drain, (state_r == ST_RUN) && (k_r == '0), state_r == ST_DRAIN)
  `DREK_NEXT(a_last_to_done, hit.last, state_r == ST_DONE)

endmodule
`default_nettype wire

[rtl/drek_cell.sv]
// One storage cell of the kernel point chain.
`default_nettype none
module drek_cell (
  input  wire logic             clk,
  input  wire logic             shift,
  input  wire drek_pkg::point_t d,
  output drek_pkg::point_t      q
);

  drek_pkg::point_t pt_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      pt_r <= d;
    end
  end

  assign q = pt_r;

endmodule
`default_nettype wire

[rtl/drek_eval.sv]
// Pipelined window, drift, rotation and ellipse test of one point per cycle.
`default_nettype none
module drek_eval (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire drek_pkg::cfg_t   cfg,
  input  wire drek_pkg::site_t  site,
  input  wire logic             pt_vld,
  input  wire logic             pt_last,
  input  wire drek_pkg::point_t pt,
  output drek_pkg::tag_t        hit
);

  localparam logic [81:0] ONE_Q48_82 = 82'(1) << 48;
  localparam logic [49:0] ONE_Q48_50 = 50'(1) << 48;
  localparam logic [53:0] M_LIMIT    = 54'(1) << 24;

  drek_pkg::tag_t tag_r   [drek_pkg::EVAL_STAGES];
  drek_pkg::tag_t tag_nxt [drek_pkg::EVAL_STAGES];

  // stage 1
  logic signed [32:0] dt;
  logic               in_time, in_win;
  logic [30:0]        dt_r;
  logic signed [31:0] px1_r, py1_r;
  // stage 2
  logic signed [63:0] mx_r, my_r;
  logic signed [31:0] px2_r, py2_r;
  // stage 3
  logic signed [63:0] mxr, myr;
  logic signed [49:0] dx_r, dy_r;
  // stage 4
  logic signed [65:0] xc_r, ys_r, yc_r, xs_r;
  // stage 5
  logic signed [66:0] u_r, v_r;
  // stage 6
  logic [66:0]        au, av;
  logic [67:0]        ru, rv;
  logic [53:0]        mu, mv;
  logic [24:0]        mu_r, mv_r;
  // stage 7
  logic [49:0]        squ_r, sqv_r;
  // stage 8
  logic [55:0]        plu_r, plv_r;
  logic [57:0]        phu_r, phv_r;
  // stage 9
  logic [81:0]        termu, termv;
  logic [48:0]        ta_r, tb_r;

  assign dt      = 33'(site.t) - 33'(pt.t);
  assign in_time = pt.t <= site.t;
  assign in_win  = dt < $signed({2'b00, cfg.window});

  assign mxr = (mx_r + 64'sd32768) >>> 16;
  assign myr = (my_r + 64'sd32768) >>> 16;

  assign au = u_r[66] ? (~u_r + 67'd1) : u_r;
  assign av = v_r[66] ? (~v_r + 67'd1) : v_r;
  assign ru = 68'(au) + 68'd8192;
  assign rv = 68'(av) + 68'd8192;
  assign mu = ru[67:14];
  assign mv = rv[67:14];

  assign termu = {phu_r, 24'd0} + 82'(plu_r);
  assign termv = {phv_r, 24'd0} + 82'(plv_r);

  always_ff @(posedge clk) begin
    // datapath
    dt_r  <= dt[30:0];
    px1_r <= pt.x;
    py1_r <= pt.y;
    mx_r  <= 64'($signed({1'b0, dt_r})) * 64'(cfg.drift_x);
    my_r  <= 64'($signed({1'b0, dt_r})) * 64'(cfg.drift_y);
    px2_r <= px1_r;
    py2_r <= py1_r;
    dx_r  <= 50'(px2_r) - 50'(site.x) + 50'(mxr);
    dy_r  <= 50'(py2_r) - 50'(site.y) + 50'(myr);
    xc_r  <= 66'(dx_r) * 66'(cfg.cos_a);
    ys_r  <= 66'(dy_r) * 66'(cfg.sin_a);
    yc_r  <= 66'(dy_r) * 66'(cfg.cos_a);
    xs_r  <= 66'(dx_r) * 66'(cfg.sin_a);
    u_r   <= 67'(xc_r) + 67'(ys_r);
    v_r   <= 67'(yc_r) - 67'(xs_r);
    mu_r  <= mu[24:0];
    mv_r  <= mv[24:0];
    squ_r <= 50'(mu_r) * 50'(mu_r);
    sqv_r <= 50'(mv_r) * 50'(mv_r);
    plu_r <= 56'(squ_r[23:0]) * 56'(cfg.inv_a);
    phu_r <= 58'(squ_r[49:24]) * 58'(cfg.inv_a);
    plv_r <= 56'(sqv_r[23:0]) * 56'(cfg.inv_b);
    phv_r <= 58'(sqv_r[49:24]) * 58'(cfg.inv_b);
    ta_r  <= termu[48:0];
    tb_r  <= termv[48:0];
  end

  always_comb begin
    tag_nxt[0].vld  = pt_vld;
    tag_nxt[0].last = pt_last;
    tag_nxt[0].keep = pt_vld && in_time && in_win;
    tag_nxt[0].w    = pt.w;
    for (int i = 1; i < drek_pkg::EVAL_STAGES; i++) begin
      tag_nxt[i] = tag_r[i-1];
    end
    // drop points whose rotated offset is far outside or that fall outside the ellipse
    tag_nxt[5].keep = tag_r[4].keep && (mu <= M_LIMIT) && (mv <= M_LIMIT);
    tag_nxt[8].keep = tag_r[7].keep && (termu <= ONE_Q48_82) && (termv <= ONE_Q48_82);
    tag_nxt[9].keep = tag_r[8].keep && ((50'(ta_r) + 50'(tb_r)) <= ONE_Q48_50);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < drek_pkg::EVAL_STAGES; i++) begin
        tag_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < drek_pkg::EVAL_STAGES; i++) begin
        tag_r[i] <= tag_nxt[i];
      end
    end
  end

  assign hit = tag_r[drek_pkg::EVAL_STAGES-1];

endmodule
`default_nettype wire
